>>> rtl/core/segcol_pkg.sv
// Shared types, constants and the arctangent table of the segment collinearity test.
package segcol_pkg;

  localparam int COORD_BITS         = 12;
  localparam int CORDIC_PRESHIFT    = 8;
  localparam int CORDIC_W           = COORD_BITS + 11;
  localparam int CORDIC_PER_STAGE   = 4;
  localparam int ANGLE_W            = 18;
  localparam int ANGLE_PI_HALF      = 12868;
  localparam int ANGLE_LIMIT        = 715;
  localparam int PROD_W             = 2 * COORD_BITS + 2;
  localparam int NUM_W              = 2 * COORD_BITS + 2;
  localparam int DIVIDEND_W         = NUM_W + 4;
  localparam int QUOT_BITS          = 20;
  localparam int DIV_PER_STAGE      = 4;
  localparam int DIV_STAGES         = QUOT_BITS / DIV_PER_STAGE;
  localparam int SUM_W              = QUOT_BITS + 2;
  localparam int THRESH_W           = 16;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd240;

  localparam logic [1:0] OUT_MERGED   = 2'd0;
  localparam logic [1:0] OUT_ANGLE    = 2'd1;
  localparam logic [1:0] OUT_VERTICAL = 2'd2;
  localparam logic [1:0] OUT_DISTANCE = 2'd3;

  typedef struct packed {
    logic [11:0] first_x0;
    logic [11:0] first_y0;
    logic [11:0] first_x1;
    logic [11:0] first_y1;
    logic [11:0] second_x0;
    logic [11:0] second_y0;
    logic [11:0] second_x1;
    logic [11:0] second_y1;
  } request_t;

  typedef struct packed {
    logic       mergeable;
    logic [1:0] outcome;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
  } segment_t;

  // atan(2^-i) in Q3.13, rounded to nearest.
  function automatic logic signed [ANGLE_W-1:0] atan_entry(input int idx);
    logic signed [ANGLE_W-1:0] v;
    begin
      case (idx)
        0:       v = 18'sd6434;
        1:       v = 18'sd3798;
        2:       v = 18'sd2007;
        3:       v = 18'sd1019;
        4:       v = 18'sd511;
        5:       v = 18'sd256;
        6:       v = 18'sd128;
        7:       v = 18'sd64;
        8:       v = 18'sd32;
        9:       v = 18'sd16;
        10:      v = 18'sd8;
        11:      v = 18'sd4;
        12:      v = 18'sd2;
        13:      v = 18'sd1;
        default: v = 18'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> rtl/core/segcol_cordic.sv
// Pipelined vectoring CORDIC that returns the angle of a segment direction.
module segcol_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                    clk,
  input  logic signed [segcol_pkg::COORD_BITS:0]  dx,
  input  logic signed [segcol_pkg::COORD_BITS:0]  dy,
  output logic signed [segcol_pkg::ANGLE_W-1:0]   angle
);

  localparam int W    = segcol_pkg::CORDIC_W;
  localparam int C    = segcol_pkg::COORD_BITS;
  localparam int AW   = segcol_pkg::ANGLE_W;
  localparam int PS   = segcol_pkg::CORDIC_PER_STAGE;
  localparam int NSTG = (STEPS + PS - 1) / PS;
  localparam int EXT  = W - C - 1 - segcol_pkg::CORDIC_PRESHIFT;

  logic signed [W-1:0]   x   [0:NSTG];
  logic signed [W-1:0]   y   [0:NSTG];
  logic signed [AW-1:0]  z   [0:NSTG];

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;

  assign xs = {{EXT{dx[C]}}, dx, {segcol_pkg::CORDIC_PRESHIFT{1'b0}}};
  assign ys = {{EXT{dy[C]}}, dy, {segcol_pkg::CORDIC_PRESHIFT{1'b0}}};

  // A leftward vector is first turned by a quarter so the iterations converge.
  always_ff @(posedge clk) begin
    if (xs < 0) begin
      if (ys >= 0) begin
        x[0] <= ys;
        y[0] <= -xs;
        z[0] <= AW'(segcol_pkg::ANGLE_PI_HALF);
      end else begin
        x[0] <= -ys;
        y[0] <= xs;
        z[0] <= -AW'(segcol_pkg::ANGLE_PI_HALF);
      end
    end else begin
      x[0] <= xs;
      y[0] <= ys;
      z[0] <= '0;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic signed [W-1:0]  xn;
    logic signed [W-1:0]  yn;
    logic signed [AW-1:0] zn;

    always_comb begin
      logic signed [W-1:0] sx;
      logic signed [W-1:0] sy;
      xn = x[s];
      yn = y[s];
      zn = z[s];
      sx = '0;
      sy = '0;
      for (int k = 0; k < PS; k++) begin
        if (s * PS + k < STEPS) begin
          sx = xn >>> (s * PS + k);
          sy = yn >>> (s * PS + k);
          if (yn >= 0) begin
            xn = xn + sy;
            yn = yn - sx;
            zn = zn + segcol_pkg::atan_entry(s * PS + k);
          end else begin
            xn = xn - sy;
            yn = yn + sx;
            zn = zn - segcol_pkg::atan_entry(s * PS + k);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      x[s+1] <= xn;
      y[s+1] <= yn;
      z[s+1] <= zn;
    end
  end

  assign angle = z[NSTG];

endmodule

>>> rtl/core/segcol_div.sv
// Pipelined restoring divider giving a saturated 20-bit quotient.
module segcol_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [segcol_pkg::NUM_W-1:0]          numer,
  input  logic [segcol_pkg::COORD_BITS-1:0]     denom,
  output logic                                  out_valid,
  output logic [segcol_pkg::QUOT_BITS-1:0]      quot
);

  localparam int C  = segcol_pkg::COORD_BITS;
  localparam int DW = segcol_pkg::DIVIDEND_W;
  localparam int QB = segcol_pkg::QUOT_BITS;
  localparam int DS = segcol_pkg::DIV_STAGES;
  localparam int PS = segcol_pkg::DIV_PER_STAGE;
  localparam int RW = C + 1;

  logic          vld [0:DS];
  logic          sat [0:DS];
  logic [RW-1:0] rem [0:DS];
  logic [QB-1:0] q   [0:DS];
  logic [QB-1:0] lo  [0:DS];
  logic [C-1:0]  d   [0:DS];

  logic [DW-1:0] dividend;
  logic [DW-1:0] hi;

  assign dividend = {numer, 4'b0000};
  assign hi       = dividend >> QB;

  // A quotient of 2^20 or more saturates, so the remaining remainder is narrow.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    sat[0] <= (hi >= DW'(denom));
    rem[0] <= RW'(hi);
    q[0]   <= '0;
    lo[0]  <= dividend[QB-1:0];
    d[0]   <= denom;
  end

  for (genvar s = 0; s < DS; s++) begin : g_stage
    logic [RW-1:0] rn;
    logic [QB-1:0] qn;

    always_comb begin
      rn = rem[s];
      qn = q[s];
      for (int k = 0; k < PS; k++) begin
        rn = {rn[RW-2:0], lo[s][QB-1-(s*PS+k)]};
        if (rn >= RW'(d[s])) begin
          rn = rn - RW'(d[s]);
          qn[QB-1-(s*PS+k)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      sat[s+1] <= sat[s];
      rem[s+1] <= rn;
      q[s+1]   <= qn;
      lo[s+1]  <= lo[s];
      d[s+1]   <= d[s];
    end
  end

  assign out_valid = vld[DS];
  assign quot      = sat[DS] ? {QB{1'b1}} : q[DS];

endmodule

>>> rtl/core/segcol_vdist.sv
// Summed vertical error of each segment's endpoints against the other segment's line.
module segcol_vdist (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  segcol_pkg::segment_t         first,
  input  segcol_pkg::segment_t         second,
  output logic                         out_valid,
  output logic                         vertical,
  output logic [segcol_pkg::SUM_W-1:0] sum
);

  localparam int C  = segcol_pkg::COORD_BITS;
  localparam int PW = segcol_pkg::PROD_W;
  localparam int NW = segcol_pkg::NUM_W;
  localparam int QB = segcol_pkg::QUOT_BITS;
  localparam int SW = segcol_pkg::SUM_W;
  localparam int VD = segcol_pkg::DIV_STAGES + 1;

  segcol_pkg::segment_t line_s  [0:3];
  logic [C-1:0]         pt_x    [0:3];
  logic [C-1:0]         pt_y    [0:3];

  // The first two errors test the first segment's endpoints on the second line.
  always_comb begin
    line_s[0] = second;
    line_s[1] = second;
    line_s[2] = first;
    line_s[3] = first;
    pt_x[0]   = first.x0;
    pt_y[0]   = first.y0;
    pt_x[1]   = first.x1;
    pt_y[1]   = first.y1;
    pt_x[2]   = second.x0;
    pt_y[2]   = second.y0;
    pt_x[3]   = second.x1;
    pt_y[3]   = second.y1;
  end

  logic                 v1;
  logic                 v2;
  logic                 vert1;
  logic                 vert2;
  logic signed [PW-1:0] pa [0:3];
  logic signed [PW-1:0] pb [0:3];
  logic [C-1:0]         ub1 [0:3];
  logic [NW-1:0]        un2 [0:3];
  logic [C-1:0]         ub2 [0:3];
  logic [QB-1:0]        qt  [0:3];
  logic                 dv  [0:3];
  logic                 vert_dly [0:VD-1];

  for (genvar e = 0; e < 4; e++) begin : g_err
    logic signed [C:0]    ldx;
    logic signed [C:0]    ldy;
    logic signed [C:0]    ox;
    logic signed [C:0]    oy;
    logic signed [PW:0]   num;

    // Numerator of the line equation as dy*(px-x0) - dx*(py-y0).
    assign ldx = $signed({1'b0, line_s[e].x1}) - $signed({1'b0, line_s[e].x0});
    assign ldy = $signed({1'b0, line_s[e].y1}) - $signed({1'b0, line_s[e].y0});
    assign ox  = $signed({1'b0, pt_x[e]}) - $signed({1'b0, line_s[e].x0});
    assign oy  = $signed({1'b0, pt_y[e]}) - $signed({1'b0, line_s[e].y0});
    assign num = (PW+1)'(pa[e]) - (PW+1)'(pb[e]);

    always_ff @(posedge clk) begin
      pa[e]  <= ldy * ox;
      pb[e]  <= ldx * oy;
      ub1[e] <= ldx[C] ? C'(-ldx) : ldx[C-1:0];
      un2[e] <= num[PW] ? NW'(-num) : NW'(num);
      ub2[e] <= ub1[e];
    end

    segcol_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v2),
      .numer     (un2[e]),
      .denom     (ub2[e]),
      .out_valid (dv[e]),
      .quot      (qt[e])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= dv[0] & dv[1] & dv[2] & dv[3];
    end
    vert1       <= (first.x0 == first.x1) || (second.x0 == second.x1);
    vert2       <= vert1;
    vert_dly[0] <= vert2;
    for (int i = 1; i < VD; i++) begin
      vert_dly[i] <= vert_dly[i-1];
    end
    vertical <= vert_dly[VD-1];
    sum      <= SW'(qt[0]) + SW'(qt[1]) + SW'(qt[2]) + SW'(qt[3]);
  end

endmodule

>>> rtl/core/segment_collinearity_test.sv
// Segment collinearity test: angle check, vertical check and summed vertical error check.
// done for a request rises after the input registers, the error pipeline and the result register.
// Throughput: one request per cycle; busy is always low and the result is never held.
// Latency is set by the four pipelined 20-bit dividers in the error path.
// Reset (synchronous) empties the pipeline and sets merge_threshold to 240.
module segment_collinearity_test #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  segcol_pkg::request_t request,
  output logic                 done,
  output segcol_pkg::result_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  localparam int C    = segcol_pkg::COORD_BITS;
  localparam int AW   = segcol_pkg::ANGLE_W;
  localparam int NSTG = (CORDIC_STEPS + segcol_pkg::CORDIC_PER_STAGE - 1)
                        / segcol_pkg::CORDIC_PER_STAGE;
  localparam int L_C  = 1 + NSTG;
  localparam int L_E  = 2 + 1 + segcol_pkg::DIV_STAGES + 1;
  localparam int DIFF = L_E - L_C - 1;

  logic [segcol_pkg::THRESH_W-1:0] merge_threshold;
  logic                            in_v;
  segcol_pkg::segment_t            seg1;
  segcol_pkg::segment_t            seg2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_threshold <= segcol_pkg::THRESH_RESET;
      in_v            <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        merge_threshold <= cfg_data;
      end
      in_v <= start && !busy;
    end
    seg1 <= {request.first_x0, request.first_y0, request.first_x1, request.first_y1};
    seg2 <= {request.second_x0, request.second_y0, request.second_x1, request.second_y1};
  end

  logic signed [C:0]    dx1;
  logic signed [C:0]    dy1;
  logic signed [C:0]    dx2;
  logic signed [C:0]    dy2;
  logic signed [AW-1:0] ang1;
  logic signed [AW-1:0] ang2;

  assign dx1 = $signed({1'b0, seg1.x1}) - $signed({1'b0, seg1.x0});
  assign dy1 = $signed({1'b0, seg1.y1}) - $signed({1'b0, seg1.y0});
  assign dx2 = $signed({1'b0, seg2.x1}) - $signed({1'b0, seg2.x0});
  assign dy2 = $signed({1'b0, seg2.y1}) - $signed({1'b0, seg2.y0});

  segcol_cordic #(.STEPS(CORDIC_STEPS)) u_cordic1 (
    .clk   (clk),
    .dx    (dx1),
    .dy    (dy1),
    .angle (ang1)
  );

  segcol_cordic #(.STEPS(CORDIC_STEPS)) u_cordic2 (
    .clk   (clk),
    .dx    (dx2),
    .dy    (dy2),
    .angle (ang2)
  );

  logic                 vd_valid;
  logic                 vd_vertical;
  logic [segcol_pkg::SUM_W-1:0] vd_sum;

  segcol_vdist u_vdist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_v),
    .first     (seg1),
    .second    (seg2),
    .out_valid (vd_valid),
    .vertical  (vd_vertical),
    .sum       (vd_sum)
  );

  // Angles are compared without wrap, so opposite directions fail here.
  logic signed [AW:0] da;
  logic               angle_bad;
  logic               angle_dly [0:DIFF-1];

  assign da = (AW+1)'(ang2) - (AW+1)'(ang1);

  always_ff @(posedge clk) begin
    angle_bad    <= da[AW] ? ((-da) > (AW+1)'(segcol_pkg::ANGLE_LIMIT))
                           : (da > (AW+1)'(segcol_pkg::ANGLE_LIMIT));
    angle_dly[0] <= angle_bad;
    for (int i = 1; i < DIFF; i++) begin
      angle_dly[i] <= angle_dly[i-1];
    end
  end

  logic [1:0] outcome_next;

  always_comb begin
    if (angle_dly[DIFF-1]) begin
      outcome_next = segcol_pkg::OUT_ANGLE;
    end else if (vd_vertical) begin
      outcome_next = segcol_pkg::OUT_VERTICAL;
    end else if (vd_sum < segcol_pkg::SUM_W'(merge_threshold)) begin
      outcome_next = segcol_pkg::OUT_MERGED;
    end else begin
      outcome_next = segcol_pkg::OUT_DISTANCE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd_valid;
    end
    result.outcome   <= outcome_next;
    result.mergeable <= (outcome_next == segcol_pkg::OUT_MERGED);
  end

endmodule

>>> tb/segment_collinearity_test_tb.sv
// Testbench for the segment collinearity test: directed and random pairs, scoreboard checked.
module segment_collinearity_test_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;

  class merge_scoreboard;
    segcol_pkg::result_t expected_q[$];
    logic [15:0]         threshold;
    int                  mismatches;
    int                  atan_q13[16];

    function new();
      atan_q13 = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                   32, 16, 8, 4, 2, 1, 0, 0};
      threshold  = 16'd240;
      mismatches = 0;
    endfunction

    function int seg_angle(int dx, int dy);
      int x, y, z, t, sx, sy;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = segcol_pkg::ANGLE_PI_HALF;
        end else begin
          x = -y;
          y = t;
          z = -segcol_pkg::ANGLE_PI_HALF;
        end
      end
      for (int i = 0; i < 16; i++) begin
        sx = x >>> i;
        sy = y >>> i;
        if (y >= 0) begin
          x = x + sy;
          y = y - sx;
          z = z + atan_q13[i];
        end else begin
          x = x - sy;
          y = y + sx;
          z = z - atan_q13[i];
        end
      end
      return z;
    endfunction

    function longint vert_error(longint x0, longint y0, longint x1, longint y1,
                                longint px, longint py);
      longint a, b, c, num, e;
      a   = y1 - y0;
      b   = x0 - x1;
      c   = x1 * y0 - x0 * y1;
      num = a * px + b * py + c;
      if (num < 0) num = -num;
      if (b < 0) b = -b;
      e = (num * 16) / b;
      return (e > 64'hFFFFF) ? 64'hFFFFF : e;
    endfunction

    function void note_request(segcol_pkg::request_t r);
      int a1, a2, da;
      longint sum;
      segcol_pkg::result_t res;
      a1 = seg_angle(int'(r.first_x1) - int'(r.first_x0),
                     int'(r.first_y1) - int'(r.first_y0));
      a2 = seg_angle(int'(r.second_x1) - int'(r.second_x0),
                     int'(r.second_y1) - int'(r.second_y0));
      da = a2 - a1;
      if (da < 0) da = -da;
      if (da > segcol_pkg::ANGLE_LIMIT) begin
        res.outcome = segcol_pkg::OUT_ANGLE;
      end else if (r.first_x0 == r.first_x1 || r.second_x0 == r.second_x1) begin
        res.outcome = segcol_pkg::OUT_VERTICAL;
      end else begin
        sum = vert_error(r.second_x0, r.second_y0, r.second_x1, r.second_y1,
                         r.first_x0, r.first_y0)
            + vert_error(r.second_x0, r.second_y0, r.second_x1, r.second_y1,
                         r.first_x1, r.first_y1)
            + vert_error(r.first_x0, r.first_y0, r.first_x1, r.first_y1,
                         r.second_x0, r.second_y0)
            + vert_error(r.first_x0, r.first_y0, r.first_x1, r.first_y1,
                         r.second_x1, r.second_y1);
        if (sum > 64'hFFFFF) sum = 64'hFFFFF;
        res.outcome = (sum < longint'(threshold)) ? segcol_pkg::OUT_MERGED
                                                  : segcol_pkg::OUT_DISTANCE;
      end
      res.mergeable = (res.outcome == segcol_pkg::OUT_MERGED);
      expected_q = {expected_q, res};
    endfunction

    function void check_result(segcol_pkg::result_t got);
      segcol_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mergeable=%0d outcome=%0d", got.mergeable, got.outcome);
        return;
      end
      want = expected_q.pop_front();
      if (got.mergeable !== want.mergeable || got.outcome !== want.outcome) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected mergeable=%0d outcome=%0d, got mergeable=%0d outcome=%0d",
                   want.mergeable, want.outcome, got.mergeable, got.outcome);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  segcol_pkg::request_t request = '0;
  logic                 done;
  segcol_pkg::result_t  result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [15:0]          cfg_data = '0;

  merge_scoreboard sb = new();
  int idle_cycles = 0;

  segment_collinearity_test dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Sampling of both handshakes and the result strobe.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(request);
      if (cfg_valid && cfg_ready) sb.threshold = cfg_data;
      if (done) sb.check_result(result);
      if ((start && !busy) || (cfg_valid && cfg_ready) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one request after a random gap; start stays high if the next gap is zero.
  task automatic send_request(segcol_pkg::request_t r);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    request = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    start = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic segcol_pkg::request_t make_pair(int ax, int ay, int bx, int by,
                                                     int cx, int cy, int dx, int dy);
    segcol_pkg::request_t r;
    r.first_x0  = ax[11:0];
    r.first_y0  = ay[11:0];
    r.first_x1  = bx[11:0];
    r.first_y1  = by[11:0];
    r.second_x0 = cx[11:0];
    r.second_y0 = cy[11:0];
    r.second_x1 = dx[11:0];
    r.second_y1 = dy[11:0];
    return r;
  endfunction

  // Mostly near-collinear pairs on a random line, with some vertical, some reversed and some random noise.
  function automatic segcol_pkg::request_t random_pair();
    int kind, px, py, ddx, ddy, k, m, n;
    segcol_pkg::request_t r;
    kind = $urandom_range(0, 99);
    px  = $urandom_range(800, 3300);
    py  = $urandom_range(800, 3300);
    ddx = $urandom_range(1, 300);
    if ($urandom_range(0, 1)) ddx = -ddx;
    ddy = int'($urandom_range(0, 600)) - 300;
    k   = int'($urandom_range(0, 4)) - 2;
    m   = $urandom_range(0, 7);
    n   = $urandom_range(0, 7);
    if (kind < 25) begin
      r = segcol_pkg::request_t'({$urandom, $urandom, $urandom});
    end else if (kind < 35) begin
      r = make_pair(px, py, px, py + ddy, px + m, py + 400, px + m, py + 400 + ddy);
    end else if (kind < 40) begin
      r = make_pair(px, py, px + ddx, py + ddy,
                    px + k * ddx + ddx, py + k * ddy + ddy, px + k * ddx, py + k * ddy);
    end else begin
      r = make_pair(px, py, px + ddx, py + ddy,
                    px + k * ddx + m, py + k * ddy + n,
                    px + (k + 1) * ddx + n, py + (k + 1) * ddy + m);
    end
    return r;
  endfunction

  initial begin
    logic [15:0] thresholds[5];
    thresholds = '{16'd0, 16'hFFFF, 16'd1, 16'd16, 16'd240};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pairs under the reset threshold.
    send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_request(segcol_pkg::request_t'({96{1'b1}}));
    send_request(make_pair(0, 0, 4095, 0, 0, 1, 4095, 1));
    send_request(make_pair(0, 0, 4095, 4095, 0, 0, 4095, 4095));
    send_request(make_pair(4095, 0, 0, 4095, 4095, 0, 0, 4095));
    send_request(make_pair(10, 10, 100, 10, 100, 10, 10, 10));
    send_request(make_pair(10, 10, 10, 200, 20, 10, 20, 200));
    send_request(make_pair(10, 10, 100, 20, 10, 300, 10, 300));
    send_request(make_pair(0, 0, 1, 0, 4094, 0, 4095, 0));
    send_request(make_pair(0, 0, 1, 4095, 0, 0, 1, 4095));
    send_request(make_pair(0, 4095, 1, 0, 0, 4095, 1, 0));
    send_request(make_pair(100, 100, 200, 150, 300, 200, 400, 250));
    send_request(make_pair(100, 100, 200, 150, 300, 207, 400, 257));
    send_request(make_pair(100, 100, 200, 100, 300, 104, 400, 104));
    send_request(make_pair(100, 100, 200, 100, 300, 103, 400, 103));
    send_request(make_pair(500, 500, 400, 480, 300, 460, 200, 440));
    send_request(make_pair(0, 2000, 4095, 2000, 0, 0, 4095, 8));
    send_request(make_pair(5, 5, 9, 9, 1000, 1000, 1004, 1004));
    send_request(make_pair(1, 0, 0, 4095, 3000, 0, 2999, 4095));
    send_request(make_pair(2048, 2048, 2049, 2049, 2048, 2048, 2049, 2047));

    for (int p = 0; p < 5; p++) begin
      write_threshold(p == 3 ? 16'($urandom) : thresholds[p]);
      for (int i = 0; i < 80; i++) send_request(random_pair());
    end
    start = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
